// File: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and codes of the min-heap priority queue
// Request and response records, status and action codes, cell command record.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned COUNT_W = 11;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic [10:0]        entry_count;
	} rsp_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic               ins;
		logic               pop;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage : mhpq_pkg
`default_nettype wire

// File: rtl/mhpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted key row
// Holds one key; on insert it keeps, takes the new key or takes its left
// neighbor's key; on pop it takes its right neighbor's key.
// ----------------------------------------------------------------------------
module mhpq_cell import mhpq_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 11
) (
	input  wire logic               clk,
	input  wire cell_cmd_t          cmd,
	input  wire logic [CW-1:0]      count,
	input  wire logic signed [31:0] prev_key,
	input  wire logic               prev_gt,
	input  wire logic signed [31:0] next_key,
	output logic signed [31:0]      key,
	output logic                    gt
);

	logic signed [31:0] key_q;
	logic               occ;

	// slot holds a live key when its index is below the fill count
	assign occ = CW'(IDX) < count;

	// new key belongs at or before this slot
	assign gt  = !occ || (key_q > cmd.value);
	assign key = key_q;

	// key update
	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			key_q <= prev_gt ? prev_key : cmd.value;
		end else if (cmd.pop) begin
			key_q <= next_key;
		end
	end

endmodule : mhpq_cell
`default_nettype wire

// File: rtl/min_heap_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue: priority queue over signed 32-bit keys
// Keys are kept sorted in a row of cells, smallest in cell 0. Insert shifts
// the larger keys one cell right; pop shifts every key one cell left.
// ----------------------------------------------------------------------------
//
//  channel   | signals              | handshake
//  ----------+----------------------+--------------------------------
//  request   | req (action, value)  | taken when start && !busy
//  response  | rsp (status, popped, | valid for one cycle with done,
//            |      entry_count)    | cannot be held off
//
// The cell row and the response register update at the accepting edge, and
// the response is shown in the following cycle, while busy is high.
// The row update rests on a combinational broadcast compare across the row.
// Reset clears the fill count and the control flags; no clearing pass.
// The response side has no stall; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module min_heap_priority_queue import mhpq_pkg::*; #(
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic               accept;
	logic               is_full;
	logic               is_empty;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_nxt;
	logic               busy_q;
	logic               done_q;
	rsp_t               rsp_q;
	cell_cmd_t          cmd;
	logic [1:0]         status_nxt;
	logic signed [31:0] popped_nxt;

	logic signed [31:0] keys   [DEPTH];
	logic               gts    [DEPTH];

	assign accept   = start && !busy_q;
	assign is_full  = count_q == CW'(DEPTH);
	assign is_empty = count_q == '0;

	// command to the cell row
	always_comb begin
		cmd.ins   = accept && (req.action == ACT_INSERT) && !is_full;
		cmd.pop   = accept && (req.action == ACT_POP) && !is_empty;
		cmd.value = req.value;
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] pk;
		logic               pg;
		logic signed [31:0] nk;
		if (i == 0) begin : g_first
			assign pk = keys[0];
			assign pg = 1'b0;
		end else begin : g_mid
			assign pk = keys[i-1];
			assign pg = gts[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign nk = keys[i];
		end else begin : g_nmid
			assign nk = keys[i+1];
		end
		mhpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count_q),
			.prev_key (pk),
			.prev_gt  (pg),
			.next_key (nk),
			.key      (keys[i]),
			.gt       (gts[i])
		);
	end

	// response fields and next fill count
	always_comb begin
		status_nxt = ST_OK;
		popped_nxt = '0;
		count_nxt  = count_q;
		if (req.action == ACT_INSERT) begin
			if (is_full) begin
				status_nxt = ST_FULL;
			end else begin
				count_nxt = count_q + CW'(1);
			end
		end else begin
			if (is_empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				popped_nxt = keys[0];
				count_nxt  = count_q - CW'(1);
			end
		end
	end

	// fill count and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			busy_q <= accept;
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status       <= status_nxt;
			rsp_q.popped_value <= popped_nxt;
			rsp_q.entry_count  <= COUNT_W'(count_nxt);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_done_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("response missing after request");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.action == ACT_POP && count_q != '0)
		|=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not lower fill count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> count_q == CW'(DEPTH))
		else $error("full reported below depth");

endmodule : min_heap_priority_queue
`default_nettype wire

// File: dv/heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_checker: response scoreboard for the min-heap priority queue
// Keeps a shadow binary min-heap, works out the response of every accepted
// request and compares each done strobe against the oldest one waiting.
// ----------------------------------------------------------------------------
module heap_checker import mhpq_pkg::*; #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        req,
	input  logic        done,
	input  rsp_t        rsp,
	output int unsigned error_count,
	output int unsigned outstanding,
	output int unsigned full_refusals,
	output int unsigned empty_refusals,
	output int unsigned peak_fill
);

	// shadow heap, root at entry 0
	logic signed [31:0] heap_keys [DEPTH];
	int unsigned        heap_fill;
	rsp_t               awaited_rsp [$];

	int unsigned mismatch_total;
	int unsigned full_total;
	int unsigned empty_total;
	int unsigned fill_high;

	// print one line per mismatch, keep the log bounded
	task automatic report_mismatch(input string what);
		mismatch_total++;
		if (mismatch_total <= 40)
			$display("%0t ns: heap mismatch: %s", $realtime, what);
	endtask

	function automatic void swap_keys(input int unsigned a, input int unsigned b);
		logic signed [31:0] tmp;
		tmp          = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = tmp;
	endfunction

	// apply one request to the shadow heap and return its response
	function automatic rsp_t apply_request(input req_t r);
		rsp_t        o;
		int unsigned pos;
		int unsigned par;
		int unsigned lft;
		int unsigned pick;
		logic        moving;
		o      = '0;
		moving = 1'b1;
		if (r.action == ACT_INSERT) begin
			if (heap_fill >= DEPTH) begin
				o.status = ST_FULL;
				full_total++;
			end else begin
				// append, then climb while the parent is strictly greater
				heap_keys[heap_fill] = r.value;
				pos = heap_fill;
				heap_fill++;
				while (moving && pos > 0) begin
					par = (pos - 1) / 2;
					if (heap_keys[pos] < heap_keys[par]) begin
						swap_keys(pos, par);
						pos = par;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else begin
			if (heap_fill == 0) begin
				o.status = ST_EMPTY;
				empty_total++;
			end else begin
				// take the root, move the last entry up and sink it
				o.popped_value = heap_keys[0];
				heap_fill--;
				heap_keys[0] = heap_keys[heap_fill];
				pos = 0;
				while (moving) begin
					lft = 2 * pos + 1;
					if (lft >= heap_fill) begin
						moving = 1'b0;
					end else begin
						// equal children go to the right one
						if (lft + 1 < heap_fill)
							pick = (heap_keys[lft] < heap_keys[lft + 1]) ? lft : lft + 1;
						else
							pick = lft;
						if (heap_keys[pick] < heap_keys[pos]) begin
							swap_keys(pos, pick);
							pos = pick;
						end else begin
							moving = 1'b0;
						end
					end
				end
			end
		end
		o.entry_count = heap_fill[COUNT_W-1:0];
		if (heap_fill > fill_high)
			fill_high = heap_fill;
		return o;
	endfunction

	// compare responses, then predict newly accepted requests
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			heap_fill = 0;
			awaited_rsp.delete();
			mismatch_total = 0;
			full_total     = 0;
			empty_total    = 0;
			fill_high      = 0;
		end else begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("response with no request waiting (status %0d)",
						rsp.status));
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, rsp.status));
					if (rsp.popped_value !== want.popped_value)
						report_mismatch($sformatf("popped_value expected %0d got %0d",
							want.popped_value, rsp.popped_value));
					if (rsp.entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count expected %0d got %0d",
							want.entry_count, rsp.entry_count));
				end
			end
			if (start && !busy)
				awaited_rsp.push_back(apply_request(req));
		end
		error_count    <= mismatch_total;
		outstanding    <= awaited_rsp.size();
		full_refusals  <= full_total;
		empty_refusals <= empty_total;
		peak_fill      <= fill_high;
	end

endmodule : heap_checker

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the min-heap priority queue
// Directed corner requests, then random churn, a fill past capacity and a
// pop-heavy tail, with random request gaps; responses checked by heap_checker.
// ----------------------------------------------------------------------------
module testbench;
	import mhpq_pkg::*;

	localparam int unsigned DEPTH      = 1024;
	localparam int unsigned STALL_MAX  = 1000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	int unsigned error_count;
	int unsigned outstanding;
	int unsigned full_refusals;
	int unsigned empty_refusals;
	int unsigned peak_fill;

	int unsigned sent_inserts;
	int unsigned sent_pops;
	int unsigned stall_cycles;
	logic        no_gaps;

	min_heap_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	heap_checker #(.DEPTH(DEPTH)) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req            (req),
		.done           (done),
		.rsp            (rsp),
		.error_count    (error_count),
		.outstanding    (outstanding),
		.full_refusals  (full_refusals),
		.empty_refusals (empty_refusals),
		.peak_fill      (peak_fill)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with neither a request nor a response taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("min_heap_priority_queue regression: fail");
				$finish;
			end
		end
	end

	// mostly no gap, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 40);
	endfunction

	// keys: narrow range for ties, extremes, or any 32-bit pattern
	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
			4: begin
				case ($urandom_range(0, 3))
					0: return KEY_MAX;
					1: return KEY_MIN;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $signed($urandom());
		endcase
	endfunction

	// present one request, hold it until taken, then maybe idle
	task automatic send_request(input logic act, input logic signed [31:0] key);
		req_t        r;
		int unsigned gap;
		r.action = act;
		r.value  = key;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (act == ACT_INSERT)
			sent_inserts++;
		else
			sent_pops++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending until every response is back
	task automatic wait_for_responses();
		if (start)
			start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// random requests with a given insert share in percent
	task automatic random_requests(input int unsigned count, input int unsigned insert_pct);
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 64 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < insert_pct)
				send_request(ACT_INSERT, pick_key());
			else
				send_request(ACT_POP, pick_key());
		end
	endtask

	// stimulus
	initial begin
		int unsigned guard;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		no_gaps      = 1'b0;
		sent_inserts = 0;
		sent_pops    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty, extremes, equal keys and ties between children
		send_request(ACT_POP, KEY_MAX);
		send_request(ACT_INSERT, KEY_MAX);
		send_request(ACT_INSERT, KEY_MIN);
		send_request(ACT_INSERT, 32'sd0);
		send_request(ACT_INSERT, -32'sd1);
		send_request(ACT_INSERT, 32'sh5555_5555);
		send_request(ACT_INSERT, 32'shAAAA_AAAA);
		send_request(ACT_INSERT, 32'sd0);
		send_request(ACT_INSERT, 32'sd0);
		send_request(ACT_INSERT, 32'sd1);
		send_request(ACT_POP, KEY_MIN);
		send_request(ACT_POP, 32'sd0);
		send_request(ACT_INSERT, -32'sd1);
		send_request(ACT_INSERT, -32'sd1);
		repeat (10)
			send_request(ACT_POP, 32'sd0);
		send_request(ACT_POP, 32'sd0);
		wait_for_responses();

		// churn near empty
		random_requests(16, 50);
		wait_for_responses();

		// fill to capacity and push past it
		guard = 0;
		while (full_refusals < 4 && guard < 3000) begin
			random_requests(1, 99);
			guard++;
		end
		wait_for_responses();

		// pop-heavy tail
		random_requests(10, 30);
		wait_for_responses();
		repeat (8) @(posedge clk);

		$display("sent %0d requests (%0d inserts, %0d pops), heap peaked at %0d entries",
			sent_inserts + sent_pops, sent_inserts, sent_pops, peak_fill);
		$display("full refusals %0d, empty refusals %0d, mismatches %0d",
			full_refusals, empty_refusals, error_count);
		if (error_count == 0 && outstanding == 0)
			$display("min_heap_priority_queue regression: pass");
		else
			$display("min_heap_priority_queue regression: fail");
		$finish;
	end

endmodule : testbench

// File: min_heap_priority_queue.f
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/min_heap_priority_queue.sv
dv/heap_checker.sv
dv/testbench.sv
